// File: src/tssr_pkg.sv
// Package for the typed sparse set with swap-remove.
// Holds widths, status codes and the reference-memory command type.
// No dependencies.
package tssr_pkg;

    localparam int NUM_TYPES = 16;
    localparam int TYPE_W    = 4;
    localparam int CELL_W    = 12;
    localparam int DIR_W     = 2;
    localparam int SLOT_W    = 13;
    localparam int CNT_W     = 14;
    localparam int RTYPE_W   = 5;
    localparam int REF_AW    = CELL_W + DIR_W;
    localparam int POS_AW    = TYPE_W + SLOT_W;

    localparam logic [CNT_W-1:0]   LIST_CAPACITY = 14'd8192;
    localparam logic [RTYPE_W-1:0] NO_REF        = 5'd31;

    localparam logic [DIR_W-1:0] DIR_DOWN  = 2'd0;
    localparam logic [DIR_W-1:0] DIR_EAST  = 2'd1;
    localparam logic [DIR_W-1:0] DIR_SOUTH = 2'd2;
    localparam logic [DIR_W-1:0] DIR_NONE  = 2'd3;

    localparam logic ACT_ADD    = 1'b0;
    localparam logic ACT_REMOVE = 1'b1;

    localparam logic [2:0] ST_DONE     = 3'd0;
    localparam logic [2:0] ST_IGNORED  = 3'd1;
    localparam logic [2:0] ST_EXISTS   = 3'd2;
    localparam logic [2:0] ST_FULL     = 3'd3;
    localparam logic [2:0] ST_MISMATCH = 3'd4;

    // One access to the back-reference memory.
    typedef struct packed {
        logic               rd;
        logic               wr_type;
        logic               wr_slot;
        logic [REF_AW-1:0]  addr;
        logic [RTYPE_W-1:0] rtype;
        logic [SLOT_W-1:0]  slot;
    } ref_cmd_t;

endpackage

// File: src/tssr_ref_mem.sv
// Back-reference memory: type and slot per cell and direction.
// Uses tssr_pkg; one synchronous read with registered data, per-field writes.
module tssr_ref_mem
    import tssr_pkg::*;
(
    input  logic               aclk,
    input  ref_cmd_t           cmd,
    output logic [RTYPE_W-1:0] rd_type,
    output logic [SLOT_W-1:0]  rd_slot
);

    logic [RTYPE_W-1:0] type_mem [2**REF_AW];
    logic [SLOT_W-1:0]  slot_mem [2**REF_AW];

    // Field writes and the registered read.
    always_ff @(posedge aclk) begin
        if (cmd.wr_type) begin
            type_mem[cmd.addr] <= cmd.rtype;
        end
        if (cmd.wr_slot) begin
            slot_mem[cmd.addr] <= cmd.slot;
        end
        if (cmd.rd) begin
            rd_type <= type_mem[cmd.addr];
            rd_slot <= slot_mem[cmd.addr];
        end
    end

endmodule

// File: src/typed_sparse_set_swap_remove.sv
// Top level of the typed sparse set with swap-remove.
// Uses tssr_pkg and tssr_ref_mem; holds the position-list memory and the sequencer.
//
//  channel | direction | fields (low bit up)
//  s_axis  | in        | action, pair_type, cell_index, direction
//  m_axis  | out       | status, type_count, slot
//  cfg     | in        | active_types_mask
//
// An ignored item is answered from the check state; an add waits on one
// registered read of the reference memory, a remove on further reads of the
// reference and position memories. After reset a clearing pass marks every one
// of the 16384 references empty; no transfer is accepted meanwhile. A stalled
// result holds the sequencer in its state; no new item is taken meanwhile.
module typed_sparse_set_swap_remove
    import tssr_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    // action[0], pair_type[4:1], cell_index[16:5], direction[18:17]
    input  logic [23:0] s_tdata,
    output logic        m_tvalid,
    input  logic        m_tready,
    // status[2:0], type_count[16:3], slot[29:17]
    output logic [31:0] m_tdata,
    input  logic        cfg_we,
    input  logic [15:0] cfg_wdata
);

    localparam logic [2:0] S_CLR  = 3'd0;
    localparam logic [2:0] S_IDLE = 3'd1;
    localparam logic [2:0] S_CHK  = 3'd2;
    localparam logic [2:0] S_REF  = 3'd3;
    localparam logic [2:0] S_P2   = 3'd4;
    localparam logic [2:0] S_P3   = 3'd5;
    localparam logic [2:0] S_P4   = 3'd6;

    logic [2:0]         state_reg, state_next;
    logic [REF_AW-1:0]  clr_reg;
    logic [15:0]        mask_reg;
    logic [CNT_W-1:0]   count_reg [NUM_TYPES];

    logic               act_reg;
    logic [TYPE_W-1:0]  t_reg;
    logic [CELL_W-1:0]  c_reg;
    logic [DIR_W-1:0]   d_reg;
    logic [CNT_W-1:0]   n_reg;
    logic [SLOT_W-1:0]  s_reg;
    logic [CELL_W-1:0]  m_reg;

    logic               m_valid_reg;
    logic [31:0]        m_data_reg;

    logic [CELL_W-1:0]  pos_mem [2**POS_AW];
    logic [CELL_W-1:0]  pos_q;
    logic               pos_rd, pos_wr;
    logic [POS_AW-1:0]  pos_raddr, pos_waddr;
    logic [CELL_W-1:0]  pos_wdata;

    ref_cmd_t           ref_cmd;
    logic [RTYPE_W-1:0] ref_type_q;
    logic [SLOT_W-1:0]  ref_slot_q;

    logic               out_free, accept;
    logic               emit;
    logic [2:0]         emit_status;
    logic [CNT_W-1:0]   emit_count;
    logic [SLOT_W-1:0]  emit_slot;
    logic               cnt_wr;
    logic [CNT_W-1:0]   cnt_wdata;
    logic [CNT_W-1:0]   last;

    assign out_free = !m_valid_reg || m_tready;
    assign s_tready = (state_reg == S_IDLE);
    assign accept   = s_tvalid && s_tready;
    assign m_tvalid = m_valid_reg;
    assign m_tdata  = m_data_reg;
    assign last     = n_reg - 14'd1;

    tssr_ref_mem u_ref (
        .aclk    (aclk),
        .cmd     (ref_cmd),
        .rd_type (ref_type_q),
        .rd_slot (ref_slot_q)
    );

    // Position lists, addressed by {type, slot}.
    always_ff @(posedge aclk) begin
        if (pos_wr) begin
            pos_mem[pos_waddr] <= pos_wdata;
        end
        if (pos_rd) begin
            pos_q <= pos_mem[pos_raddr];
        end
    end

    // Sequencer decisions.
    always_comb begin
        state_next  = state_reg;
        ref_cmd     = '0;
        pos_rd      = 1'b0;
        pos_wr      = 1'b0;
        pos_raddr   = {t_reg, s_reg};
        pos_waddr   = {t_reg, s_reg};
        pos_wdata   = c_reg;
        emit        = 1'b0;
        emit_status = ST_DONE;
        emit_count  = n_reg;
        emit_slot   = '0;
        cnt_wr      = 1'b0;
        cnt_wdata   = n_reg;
        unique case (state_reg)
            S_CLR: begin
                ref_cmd.wr_type = 1'b1;
                ref_cmd.addr    = clr_reg;
                ref_cmd.rtype   = NO_REF;
                if (clr_reg == '1) begin
                    state_next = S_IDLE;
                end
            end
            S_IDLE: begin
                if (accept) begin
                    state_next = S_CHK;
                end
            end
            S_CHK: begin
                if (!mask_reg[t_reg] || d_reg == DIR_NONE) begin
                    if (out_free) begin
                        emit        = 1'b1;
                        emit_status = ST_IGNORED;
                        emit_count  = count_reg[t_reg];
                        state_next  = S_IDLE;
                    end
                end else begin
                    ref_cmd.rd   = 1'b1;
                    ref_cmd.addr = {c_reg, d_reg};
                    state_next   = S_REF;
                end
            end
            S_REF: begin
                if (out_free) begin
                    if (act_reg == ACT_ADD) begin
                        emit       = 1'b1;
                        state_next = S_IDLE;
                        if (ref_type_q != NO_REF) begin
                            emit_status = ST_EXISTS;
                        end else if (n_reg >= LIST_CAPACITY) begin
                            emit_status = ST_FULL;
                        end else begin
                            ref_cmd.wr_type = 1'b1;
                            ref_cmd.wr_slot = 1'b1;
                            ref_cmd.addr    = {c_reg, d_reg};
                            ref_cmd.rtype   = {1'b0, t_reg};
                            ref_cmd.slot    = n_reg[SLOT_W-1:0];
                            pos_wr          = 1'b1;
                            pos_waddr       = {t_reg, n_reg[SLOT_W-1:0]};
                            cnt_wr          = 1'b1;
                            cnt_wdata       = n_reg + 14'd1;
                            emit_count      = n_reg + 14'd1;
                            emit_slot       = n_reg[SLOT_W-1:0];
                        end
                    end else if (ref_type_q != {1'b0, t_reg} ||
                                 {1'b0, ref_slot_q} >= n_reg) begin
                        emit        = 1'b1;
                        emit_status = ST_MISMATCH;
                        state_next  = S_IDLE;
                    end else begin
                        pos_rd     = 1'b1;
                        pos_raddr  = {t_reg, ref_slot_q};
                        state_next = S_P2;
                    end
                end
            end
            S_P2: begin
                if (out_free) begin
                    if (pos_q != c_reg) begin
                        emit        = 1'b1;
                        emit_status = ST_MISMATCH;
                        state_next  = S_IDLE;
                    end else begin
                        ref_cmd.wr_type = 1'b1;
                        ref_cmd.wr_slot = 1'b1;
                        ref_cmd.addr    = {c_reg, d_reg};
                        ref_cmd.rtype   = NO_REF;
                        ref_cmd.slot    = '0;
                        cnt_wr          = 1'b1;
                        cnt_wdata       = last;
                        if ({1'b0, s_reg} == last) begin
                            emit       = 1'b1;
                            emit_count = last;
                            emit_slot  = s_reg;
                            state_next = S_IDLE;
                        end else begin
                            pos_rd     = 1'b1;
                            pos_raddr  = {t_reg, last[SLOT_W-1:0]};
                            state_next = S_P3;
                        end
                    end
                end
            end
            S_P3: begin
                if (out_free) begin
                    // Move the last entry into the hole.
                    pos_wr    = 1'b1;
                    pos_waddr = {t_reg, s_reg};
                    pos_wdata = pos_q;
                    if (d_reg == DIR_DOWN) begin
                        ref_cmd.wr_slot = 1'b1;
                        ref_cmd.addr    = {pos_q, DIR_DOWN};
                        ref_cmd.slot    = s_reg;
                        emit            = 1'b1;
                        emit_count      = last;
                        emit_slot       = s_reg;
                        state_next      = S_IDLE;
                    end else begin
                        ref_cmd.rd   = 1'b1;
                        ref_cmd.addr = {pos_q, DIR_EAST};
                        state_next   = S_P4;
                    end
                end
            end
            S_P4: begin
                if (out_free) begin
                    // Repoint east if it names the old last slot, else south.
                    ref_cmd.wr_slot = 1'b1;
                    ref_cmd.slot    = s_reg;
                    if (ref_type_q == {1'b0, t_reg} && ref_slot_q == last[SLOT_W-1:0]) begin
                        ref_cmd.addr = {m_reg, DIR_EAST};
                    end else begin
                        ref_cmd.addr = {m_reg, DIR_SOUTH};
                    end
                    emit       = 1'b1;
                    emit_count = last;
                    emit_slot  = s_reg;
                    state_next = S_IDLE;
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    // Control state.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= S_CLR;
            clr_reg     <= '0;
            mask_reg    <= '0;
            m_valid_reg <= 1'b0;
            for (int i = 0; i < NUM_TYPES; i++) begin
                count_reg[i] <= '0;
            end
        end else begin
            state_reg <= state_next;
            if (state_reg == S_CLR) begin
                clr_reg <= clr_reg + REF_AW'(1);
            end
            if (cfg_we) begin
                mask_reg <= cfg_wdata;
            end
            if (cnt_wr) begin
                count_reg[t_reg] <= cnt_wdata;
            end
            if (emit) begin
                m_valid_reg <= 1'b1;
            end else if (m_tready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    // Item and result payload.
    always_ff @(posedge aclk) begin
        if (accept) begin
            act_reg <= s_tdata[0];
            t_reg   <= s_tdata[4:1];
            c_reg   <= s_tdata[16:5];
            d_reg   <= s_tdata[18:17];
        end
        if (state_reg == S_CHK) begin
            n_reg <= count_reg[t_reg];
        end
        if (state_reg == S_REF) begin
            s_reg <= ref_slot_q;
        end
        if (state_reg == S_P3) begin
            m_reg <= pos_q;
        end
        if (emit) begin
            m_data_reg <= {2'b00, emit_slot, emit_count, emit_status};
        end
    end

endmodule

// File: verif/tb_top.sv
// Self-checking testbench for typed_sparse_set_swap_remove.
// Depends on tssr_pkg and the block's RTL. A behavioral copy of the per-type
// position lists and back references predicts each result of the stream.
`timescale 1ns / 1ps

module tb_top;
    import tssr_pkg::*;

    localparam int NUM_CELLS = 4096;
    localparam int CAP       = 8192;
    localparam int NUM_REFS  = NUM_CELLS * 3;

    typedef struct packed {
        logic              action;
        logic [TYPE_W-1:0] ptype;
        logic [CELL_W-1:0] cell_idx;
        logic [DIR_W-1:0]  dir;
    } pair_op_t;

    // Packed from the top bit down, so status lands in the lowest bits.
    typedef struct packed {
        logic [SLOT_W-1:0] slot;
        logic [CNT_W-1:0]  count;
        logic [2:0]        status;
    } pair_outcome_t;

    logic        aclk = 1'b0;
    logic        aresetn = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [23:0] s_tdata = '0;
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [31:0] m_tdata;
    logic        cfg_we = 1'b0;
    logic [15:0] cfg_wdata = '0;

    typed_sparse_set_swap_remove dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata)
    );

    always #6 aclk = ~aclk;

    // Shadow state of the block.
    logic [CELL_W-1:0]  shadow_lists [0:NUM_TYPES*CAP-1];
    logic [CNT_W-1:0]   shadow_counts [0:NUM_TYPES-1];
    logic [RTYPE_W-1:0] shadow_rtype [0:NUM_REFS-1];
    logic [SLOT_W-1:0]  shadow_rslot [0:NUM_REFS-1];
    logic [15:0]        shadow_mask = '0;

    pair_op_t      pending_ops [$];
    pair_outcome_t expected_outcomes [$];
    int            errors = 0;
    int            status_seen [0:7];
    bit            burst_mode = 1'b1;
    bit            stall_mode = 1'b1;
    bit            took = 1'b0;
    int            burst_left = 0;
    int            gap_left = 0;

    // Applies one operation to the shadow state and returns the outcome.
    function automatic pair_outcome_t apply_pair_op(pair_op_t op);
        pair_outcome_t res;
        int base, r, n, s, last, m, mr;
        res = '0;
        base = int'(op.ptype) * CAP;
        r = int'(op.cell_idx) * 3 + int'(op.dir);
        n = shadow_counts[op.ptype];
        res.count = CNT_W'(n);
        if (!shadow_mask[op.ptype] || op.dir == DIR_NONE) begin
            res.status = ST_IGNORED;
        end else if (op.action == ACT_ADD) begin
            if (shadow_rtype[r] != NO_REF) begin
                res.status = ST_EXISTS;
            end else if (n >= CAP) begin
                res.status = ST_FULL;
            end else begin
                shadow_rtype[r] = {1'b0, op.ptype};
                shadow_rslot[r] = SLOT_W'(n);
                shadow_lists[base + n] = op.cell_idx;
                shadow_counts[op.ptype] = CNT_W'(n + 1);
                res.status = ST_DONE;
                res.slot = SLOT_W'(n);
                res.count = CNT_W'(n + 1);
            end
        end else begin
            s = shadow_rslot[r];
            if (shadow_rtype[r] != {1'b0, op.ptype} || s >= n ||
                shadow_lists[base + s] != op.cell_idx) begin
                res.status = ST_MISMATCH;
            end else begin
                last = n - 1;
                shadow_rtype[r] = NO_REF;
                shadow_rslot[r] = '0;
                shadow_counts[op.ptype] = CNT_W'(last);
                res.status = ST_DONE;
                res.count = CNT_W'(last);
                res.slot = SLOT_W'(s);
                // Fill the hole with the last entry and repoint its reference.
                if (s != last) begin
                    m = shadow_lists[base + last];
                    shadow_lists[base + s] = CELL_W'(m);
                    if (op.dir == DIR_DOWN)
                        mr = m * 3;
                    else if (shadow_rtype[m*3+1] == {1'b0, op.ptype} &&
                             shadow_rslot[m*3+1] == last)
                        mr = m * 3 + 1;
                    else
                        mr = m * 3 + 2;
                    shadow_rslot[mr] = SLOT_W'(s);
                end
            end
        end
        return res;
    endfunction

    // Sender: bursts with random gaps, items presented at the falling edge.
    always @(negedge aclk) begin
        if (!s_tvalid || took) begin
            if (burst_mode && burst_left == 0 && gap_left == 0) begin
                burst_left = $urandom_range(1, 12);
                gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
            end
            if (burst_mode && gap_left > 0 && burst_left == 0) begin
                gap_left--;
                s_tvalid <= 1'b0;
            end else if (pending_ops.size() > 0) begin
                if (burst_left > 0)
                    burst_left--;
                s_tdata <= {5'b0, pending_ops[0].dir, pending_ops[0].cell_idx,
                            pending_ops[0].ptype, pending_ops[0].action};
                s_tvalid <= 1'b1;
            end else begin
                s_tvalid <= 1'b0;
            end
        end
        took = 1'b0;
        m_tready <= stall_mode ? ($urandom_range(0, 3) != 0) : 1'b1;
    end

    // Accepted input transfers feed the predictor.
    always @(posedge aclk) begin
        if (aresetn && s_tvalid && s_tready) begin
            expected_outcomes.push_back(apply_pair_op(pending_ops.pop_front()));
            took = 1'b1;
        end
    end

    // Result monitor.
    always @(posedge aclk) begin
        pair_outcome_t got, want;
        if (aresetn && m_tvalid && m_tready) begin
            got = pair_outcome_t'(m_tdata[29:0]);
            if (expected_outcomes.size() == 0) begin
                $display("%0t: unexpected result transfer, actual %h", $realtime, got);
                errors++;
            end else begin
                want = expected_outcomes.pop_front();
                status_seen[want.status]++;
                if (got.status !== want.status)
                    $display("%0t: status expected %0d actual %0d",
                             $realtime, want.status, got.status);
                if (got.count !== want.count)
                    $display("%0t: type_count expected %0d actual %0d",
                             $realtime, want.count, got.count);
                if (got.slot !== want.slot)
                    $display("%0t: slot expected %0d actual %0d",
                             $realtime, want.slot, got.slot);
                if (got !== want)
                    errors++;
            end
        end
    end

    task automatic queue_op(logic act, int t, int c, int d);
        pair_op_t op;
        op.action = act;
        op.ptype = TYPE_W'(t);
        op.cell_idx = CELL_W'(c);
        op.dir = DIR_W'(d);
        pending_ops.push_back(op);
    endtask

    task automatic wait_drained();
        while (pending_ops.size() != 0 || expected_outcomes.size() != 0 || s_tvalid)
            @(posedge aclk);
        repeat (8) @(posedge aclk);
    endtask

    task automatic write_mask(logic [15:0] value);
        @(negedge aclk);
        cfg_we <= 1'b1;
        cfg_wdata <= value;
        @(negedge aclk);
        cfg_we <= 1'b0;
        shadow_mask = value;
    endtask

    // Mostly well-formed traffic on a small cell pool, some full-range noise.
    task automatic queue_random(int count);
        int t;
        for (int i = 0; i < count; i++) begin
            if ($urandom_range(0, 6) == 0) begin
                queue_op(1'($urandom_range(0, 1)), $urandom_range(0, 15),
                         $urandom_range(0, 4095), $urandom_range(0, 3));
            end else begin
                t = $urandom_range(0, 15);
                while (shadow_mask != 0 && !shadow_mask[t])
                    t = $urandom_range(0, 15);
                queue_op(1'($urandom_range(0, 1)), t, $urandom_range(0, 23),
                         $urandom_range(0, 2));
            end
        end
    endtask

    initial begin
        foreach (shadow_rtype[i]) shadow_rtype[i] = NO_REF;
        foreach (shadow_rslot[i]) shadow_rslot[i] = '0;
        foreach (shadow_counts[i]) shadow_counts[i] = '0;
        foreach (status_seen[i]) status_seen[i] = 0;
        repeat (4) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;
        // The block clears its reference memory before taking transfers.
        do @(posedge aclk); while (!s_tready);

        // Everything ignored while no type is active.
        write_mask(16'h0000);
        queue_op(ACT_ADD, 0, 0, 0);
        queue_op(ACT_REMOVE, 15, 4095, 2);
        wait_drained();

        // Directed cases with all types active.
        write_mask(16'hFFFF);
        queue_op(ACT_ADD, 0, 0, 0);
        queue_op(ACT_ADD, 15, 4095, 2);
        queue_op(ACT_ADD, 0, 0, 0);        // reference already present
        queue_op(ACT_ADD, 3, 7, DIR_NONE); // direction 3 is ignored
        queue_op(ACT_REMOVE, 4, 9, 1);     // absent reference
        queue_op(ACT_REMOVE, 1, 0, 0);     // reference of another type
        queue_op(ACT_ADD, 2, 10, 1);
        queue_op(ACT_ADD, 2, 11, 2);
        queue_op(ACT_ADD, 2, 12, 1);
        queue_op(ACT_ADD, 2, 13, 2);
        queue_op(ACT_REMOVE, 2, 10, 1);    // last south entry moves into the hole
        queue_op(ACT_REMOVE, 2, 11, 2);    // east entry moves in
        queue_op(ACT_ADD, 6, 20, 0);
        queue_op(ACT_ADD, 6, 21, 0);
        queue_op(ACT_REMOVE, 6, 20, 0);    // down remove with a move
        queue_op(ACT_REMOVE, 6, 20, 0);    // already gone
        queue_op(ACT_REMOVE, 15, 4095, 2);
        wait_drained();

        // Random phases over several masks; the drain between them is a full pause.
        write_mask(16'h8001);
        queue_random(200);
        wait_drained();
        write_mask(16'hFFFF);
        queue_random(200);
        wait_drained();
        write_mask(16'h00A5);
        stall_mode = 1'b0;
        queue_random(150);
        wait_drained();
        stall_mode = 1'b1;
        burst_mode = 1'b0;
        write_mask(16'($urandom_range(1, 65535)));
        queue_random(150);
        wait_drained();
        burst_mode = 1'b1;
        write_mask(16'hFFFF);
        queue_random(100);
        wait_drained();

        repeat (20) @(posedge aclk);
        $display("Results by status: done %0d, ignored %0d, exists %0d, full %0d, mismatch %0d",
                 status_seen[0], status_seen[1], status_seen[2], status_seen[3],
                 status_seen[4]);
        $display("Covered mask changes, rejected operations and list swaps in all directions.");
        if (errors == 0 && expected_outcomes.size() == 0)
            $display("*** PASSED ***");
        else
            $display("*** FAILED ***");
        $finish;
    end

    // Watchdog.
    initial begin
        #40ms;
        $display("Timeout with %0d results outstanding.", expected_outcomes.size());
        $display("*** FAILED ***");
        $finish;
    end

endmodule

// File: filelist.f
src/tssr_pkg.sv
src/tssr_ref_mem.sv
src/typed_sparse_set_swap_remove.sv
verif/tb_top.sv
